// File: hdl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// shared types and constants of the timer table engine: action codes, table
// sizes and the layout of one stored timer entry
// ----------------------------------------------------------------------------
package tte_pkg;

    localparam int NUM_TIMERS_DEF = 64;
    localparam int MAX_RESULTS    = 64;

    localparam int ACTION_W   = 3;
    localparam int ID_W       = 7;
    localparam int TICK_W     = 32;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESET  = 3'd4;

    // one timer entry as held in the slot memory
    typedef struct packed {
        logic              in_use;
        logic              paused;
        logic              rpt;
        logic [TICK_W-1:0] deadline;
        logic [TICK_W-1:0] interval;
    } slot_word_t;

endpackage

// File: hdl/timer_table_engine.sv
// ----------------------------------------------------------------------------
// timer_table_engine
// table of one-shot and periodic timers driven by tick, build, remove, pause
// and reset items
// ----------------------------------------------------------------------------
// Usage: items enter on the s_ channel (action, timer_id, interval,
// repeat_mode) and results leave on the m_ channel, one transfer per result.
// A tick gives one result per expiring timer, up to MAX_RESULTS, in ascending
// slot order, or one empty result when nothing expires; every other item
// gives one result. The final result of an item carries m_last.
// All timer entries live in one slot memory with a registered read.
// A tick walks every slot at one slot per cycle while the walk is not held by
// the output. A build walks slots up to the first free one. Remove, pause and
// reset read and write back one entry; a bad id or an unknown action goes
// straight to its result.
// One finished result waits in the output register, so a stalled receiver
// costs nothing until the walk has a second result to hand over; then the
// walk holds on the current slot until the output register frees.
// After reset a clearing pass writes every slot free with s_ready low; the
// tick count starts at zero.
// ----------------------------------------------------------------------------
module timer_table_engine #(
    parameter int NUM_TIMERS = tte_pkg::NUM_TIMERS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tte_pkg::ACTION_W-1:0] s_action,
    input  logic [tte_pkg::ID_W-1:0]     s_timer_id,
    input  logic [tte_pkg::TICK_W-1:0]   s_interval,
    input  logic                        s_repeat_mode,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tte_pkg::ID_W-1:0]     m_result_id,
    output logic                        m_ok,
    output logic                        m_expired,
    output logic [tte_pkg::TICK_W-1:0]   m_tick_now,
    output logic                        m_last
);
    import tte_pkg::*;

    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW     = (SLOT_W + 1 > ID_W) ? SLOT_W + 1 : ID_W;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_TICK   = 3'd2;
    localparam logic [2:0] ST_BUILD  = 3'd3;
    localparam logic [2:0] ST_SINGLE = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // slot memory
    slot_word_t mem [NUM_TIMERS];
    slot_word_t rd_word_reg;
    logic              mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;
    slot_word_t        mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_word_reg <= mem[mem_raddr];
        end
    end

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TICK_W-1:0]   ival_reg, ival_next;
    logic                rpt_reg, rpt_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ID_W-1:0]     fin_id_reg, fin_id_next;
    logic                fin_ok_reg, fin_ok_next;
    logic                fin_exp_reg, fin_exp_next;

    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     m_result_id_reg, m_result_id_next;
    logic                m_ok_reg, m_ok_next;
    logic                m_expired_reg, m_expired_next;
    logic [TICK_W-1:0]   m_tick_now_reg, m_tick_now_next;
    logic                m_last_reg, m_last_next;

    logic              out_free, out_push;
    logic              in_xfer;
    logic [CW-1:0]     id_ext;
    logic              id_good;
    logic [SLOT_W-1:0] id_slot;
    logic [ID_W-1:0]   idx_id;
    logic              hit, report, stall;
    slot_word_t        w;
    logic [TICK_W-1:0] new_ival;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign id_ext   = CW'(s_timer_id);
    assign id_good  = (id_ext != '0) && (id_ext <= CW'(NUM_TIMERS));
    assign id_slot  = SLOT_W'(id_ext - CW'(1));
    assign idx_id   = ID_W'(CW'(idx_reg) + CW'(1));
    assign w        = rd_word_reg;
    assign hit      = w.in_use && !w.paused && (w.deadline == tick_reg);
    assign report   = hit && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign stall    = report && pend_valid_reg && !out_free;
    assign new_ival = (ival_reg != '0) ? ival_reg : w.interval;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        act_next         = act_reg;
        id_next          = id_reg;
        ival_next        = ival_reg;
        rpt_next         = rpt_reg;
        tick_next        = tick_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        cnt_next         = cnt_reg;
        fin_id_next      = fin_id_reg;
        fin_ok_next      = fin_ok_reg;
        fin_exp_next     = fin_exp_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = w;
        mem_re           = 1'b0;
        mem_raddr        = idx_reg;
        out_push         = 1'b0;
        m_result_id_next = m_result_id_reg;
        m_ok_next        = m_ok_reg;
        m_expired_next   = m_expired_reg;
        m_tick_now_next  = m_tick_now_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    act_next  = s_action;
                    id_next   = s_timer_id;
                    ival_next = s_interval;
                    rpt_next  = s_repeat_mode;
                    idx_next  = '0;
                    unique case (s_action) inside
                        ACT_TICK: begin
                            tick_next       = tick_reg + TICK_W'(1);
                            pend_valid_next = 1'b0;
                            cnt_next        = '0;
                            mem_re          = 1'b1;
                            mem_raddr       = '0;
                            state_next      = ST_TICK;
                        end
                        ACT_BUILD: begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = ST_BUILD;
                        end
                        ACT_REMOVE, ACT_PAUSE, ACT_RESET: begin
                            if (id_good) begin
                                idx_next   = id_slot;
                                mem_re     = 1'b1;
                                mem_raddr  = id_slot;
                                state_next = ST_SINGLE;
                            end else begin
                                fin_id_next  = s_timer_id;
                                fin_ok_next  = 1'b0;
                                fin_exp_next = 1'b0;
                                state_next   = ST_FIN;
                            end
                        end
                        default: begin
                            fin_id_next  = s_timer_id;
                            fin_ok_next  = 1'b0;
                            fin_exp_next = 1'b0;
                            state_next   = ST_FIN;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (!stall) begin
                    if (hit) begin
                        mem_we = 1'b1;
                        if (w.rpt) begin
                            mem_wdata.deadline = tick_reg + w.interval;
                        end else begin
                            mem_wdata.in_use = 1'b0;
                        end
                    end
                    if (report) begin
                        // the held expiry is not the final one: hand it over
                        if (pend_valid_reg) begin
                            out_push         = 1'b1;
                            m_result_id_next = pend_id_reg;
                            m_ok_next        = 1'b1;
                            m_expired_next   = 1'b1;
                            m_last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = idx_id;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                    if (idx_reg == LAST_SLOT) begin
                        fin_id_next     = pend_valid_next ? pend_id_next : '0;
                        fin_ok_next     = 1'b1;
                        fin_exp_next    = pend_valid_next;
                        pend_valid_next = 1'b0;
                        state_next      = ST_FIN;
                    end else begin
                        idx_next  = idx_reg + SLOT_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + SLOT_W'(1);
                    end
                end
            end
            ST_BUILD: begin
                if (!w.in_use) begin
                    mem_we             = 1'b1;
                    mem_wdata.in_use   = 1'b1;
                    mem_wdata.paused   = 1'b0;
                    mem_wdata.rpt      = rpt_reg;
                    mem_wdata.interval = ival_reg;
                    mem_wdata.deadline = tick_reg + ival_reg;
                    fin_id_next        = idx_id;
                    fin_ok_next        = 1'b1;
                    fin_exp_next       = 1'b0;
                    state_next         = ST_FIN;
                end else if (idx_reg == LAST_SLOT) begin
                    fin_id_next  = '0;
                    fin_ok_next  = 1'b0;
                    fin_exp_next = 1'b0;
                    state_next   = ST_FIN;
                end else begin
                    idx_next  = idx_reg + SLOT_W'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + SLOT_W'(1);
                end
            end
            ST_SINGLE: begin
                mem_we = w.in_use;
                unique case (act_reg) inside
                    ACT_REMOVE: mem_wdata.in_use = 1'b0;
                    ACT_PAUSE:  mem_wdata.paused = 1'b1;
                    default: begin
                        mem_wdata.interval = new_ival;
                        mem_wdata.paused   = 1'b0;
                        mem_wdata.deadline = tick_reg + new_ival;
                    end
                endcase
                fin_id_next  = id_reg;
                fin_ok_next  = w.in_use;
                fin_exp_next = 1'b0;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    out_push         = 1'b1;
                    m_result_id_next = fin_id_reg;
                    m_ok_next        = fin_ok_reg;
                    m_expired_next   = fin_exp_reg;
                    m_last_next      = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // the tick count travels with the result so a later tick cannot change it
        if (out_push) begin
            m_valid_next    = 1'b1;
            m_tick_now_next = tick_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        id_reg          <= id_next;
        ival_reg        <= ival_next;
        rpt_reg         <= rpt_next;
        pend_id_reg     <= pend_id_next;
        fin_id_reg      <= fin_id_next;
        fin_ok_reg      <= fin_ok_next;
        fin_exp_reg     <= fin_exp_next;
        m_result_id_reg <= m_result_id_next;
        m_ok_reg        <= m_ok_next;
        m_expired_reg   <= m_expired_next;
        m_tick_now_reg  <= m_tick_now_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_result_id = m_result_id_reg;
    assign m_ok        = m_ok_reg;
    assign m_expired   = m_expired_reg;
    assign m_tick_now  = m_tick_now_reg;
    assign m_last      = m_last_reg;

    // a held result is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> out_free)
        else $error("result pushed while output register still held");

    // the walk never writes the slot it reads in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("slot memory read and write to the same slot");

    // a held expiry only exists while a tick walks the table
    a_pend_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == ST_TICK))
        else $error("pending expiry outside a tick walk");

    // an accepted item always leaves idle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start");

    // the final result of an item always carries the last flag
    a_fin_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (m_valid_reg && m_last_reg))
        else $error("final result without last flag");

endmodule
